[rtl/core/tmb_pkg.sv]
`default_nettype none

package tmb_pkg;

    // fixed field widths
    localparam int COUNT_W = 16;
    localparam int INDEX_W = 4;
    localparam int MASK_W  = 16;

    // command codes
    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_ALLOCATE     = 3'd1,
        CMD_RESTART      = 3'd2,
        CMD_PAUSE_RESUME = 3'd3,
        CMD_SET_TIME     = 3'd4,
        CMD_DELETE       = 3'd5,
        CMD_QUERY        = 3'd6
    } cmd_t;

    // request broadcast to every slot lane
    typedef struct packed {
        logic               fire;
        cmd_t               cmd;
        logic [COUNT_W-1:0] time_value;
        logic               auto_delete;
        logic               resume;
    } lane_req_t;

    // state reported by one slot lane
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               running;
        logic               used;
        logic               expire;
    } lane_stat_t;

endpackage

`default_nettype wire

[rtl/core/multi_slot_timer_bank.sv]
// Bank of TIMER_SLOTS 16-bit down-counting timer slots driven by one request
// stream (tick, allocate, restart, pause/resume, set-time, delete, query).
// Every request gives exactly one result. A request is taken into an input
// register and executed against the slot state once the result register is
// free or draining, while the result register loads; the result can be taken
// at an edge when the output is not stalled. The bank takes one request per
// clock while the output is not stalled, sustained:
// all slots decrement in parallel on a tick and allocation is a single
// priority encode over the used marks, so the one execute stage sets the rate.
// slot_index and expired_mask carry the low 16 slots when TIMER_SLOTS > 16.
`default_nettype none

module multi_slot_timer_bank #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    command,
    input  wire logic [tmb_pkg::INDEX_W-1:0]   timer_index,
    input  wire logic [tmb_pkg::COUNT_W-1:0]   time_value,
    input  wire logic                          auto_delete,
    input  wire logic                          resume,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic [tmb_pkg::INDEX_W-1:0]        slot_index,
    output logic [tmb_pkg::COUNT_W-1:0]        remaining,
    output logic [tmb_pkg::MASK_W-1:0]         expired_mask,
    output logic                               finished
);

    // input register
    logic                        in_valid_reg;
    logic [2:0]                  command_reg;
    logic [tmb_pkg::INDEX_W-1:0] index_reg;
    logic [tmb_pkg::COUNT_W-1:0] time_reg;
    logic                        auto_delete_reg;
    logic                        resume_reg;

    // result register
    logic                        out_valid_reg;
    logic                        ok_reg;
    logic                        ok_next;
    logic [tmb_pkg::INDEX_W-1:0] slot_reg;
    logic [tmb_pkg::INDEX_W-1:0] slot_next;
    logic [tmb_pkg::COUNT_W-1:0] remaining_reg;
    logic [tmb_pkg::COUNT_W-1:0] remaining_next;
    logic [tmb_pkg::MASK_W-1:0]  expired_reg;
    logic [tmb_pkg::MASK_W-1:0]  expired_next;
    logic                        finished_reg;
    logic                        finished_next;

    logic                        exec;
    tmb_pkg::cmd_t               cmd;
    tmb_pkg::lane_req_t          req;
    tmb_pkg::lane_stat_t         stat [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0]      used_vec;
    logic [TIMER_SLOTS-1:0]      running_vec;
    logic [TIMER_SLOTS-1:0]      expire_vec;
    logic [TIMER_SLOTS-1:0]      sel_vec;
    logic [TIMER_SLOTS-1:0]      grant_vec;
    logic                        alloc_found;
    logic [tmb_pkg::INDEX_W-1:0] alloc_slot;
    logic                        index_ok;
    logic [tmb_pkg::COUNT_W-1:0] sel_count;
    logic                        sel_used;

    // handshake: execute when the result register is free or draining
    assign exec     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !exec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            command_reg     <= command;
            index_reg       <= timer_index;
            time_reg        <= time_value;
            auto_delete_reg <= auto_delete;
            resume_reg      <= resume;
        end
    end

    // request to the lanes
    assign cmd             = tmb_pkg::cmd_t'(command_reg);
    assign req.fire        = exec;
    assign req.cmd         = cmd;
    assign req.time_value  = time_reg;
    assign req.auto_delete = auto_delete_reg;
    assign req.resume      = resume_reg;

    assign index_ok = (32'(index_reg) < TIMER_SLOTS);

    // slot lanes
    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++)
        begin : g_lane
            assign sel_vec[g] = index_ok && (32'(index_reg) == g);

            tmb_slot_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .req   (req),
                .sel   (sel_vec[g]),
                .grant (grant_vec[g]),
                .stat  (stat[g])
            );

            assign used_vec[g]    = stat[g].used;
            assign running_vec[g] = stat[g].running;
            assign expire_vec[g]  = stat[g].expire;
        end
    endgenerate

    // free slot search
    tmb_alloc #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_alloc (
        .used  (used_vec),
        .found (alloc_found),
        .grant (grant_vec),
        .slot  (alloc_slot)
    );

    // addressed slot read
    always_comb
    begin
        sel_count = '0;
        sel_used  = 1'b0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            if (sel_vec[i])
            begin
                sel_count = stat[i].count;
                sel_used  = stat[i].used;
            end
        end
    end

    // expired mask carries the low slots only
    generate
        for (g = 0; g < tmb_pkg::MASK_W; g++)
        begin : g_mask
            if (g < TIMER_SLOTS)
            begin : g_live
                assign expired_next[g] = expire_vec[g];
            end
            else
            begin : g_pad
                assign expired_next[g] = 1'b0;
            end
        end
    endgenerate

    // result fields
    always_comb
    begin
        ok_next        = 1'b0;
        slot_next      = index_reg;
        remaining_next = '0;
        finished_next  = 1'b0;
        case (cmd)
            tmb_pkg::CMD_TICK:
            begin
                ok_next = 1'b1;
            end
            tmb_pkg::CMD_ALLOCATE:
            begin
                ok_next   = alloc_found;
                slot_next = alloc_slot;
            end
            tmb_pkg::CMD_RESTART:
            begin
                ok_next = index_ok && (sel_count == '0);
            end
            tmb_pkg::CMD_PAUSE_RESUME, tmb_pkg::CMD_SET_TIME:
            begin
                ok_next = index_ok && (sel_count != '0);
            end
            tmb_pkg::CMD_DELETE:
            begin
                ok_next = sel_used;
            end
            tmb_pkg::CMD_QUERY:
            begin
                ok_next = sel_used;
                if (sel_used)
                begin
                    remaining_next = sel_count;
                    finished_next  = (sel_count == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            ok_reg        <= ok_next;
            slot_reg      <= slot_next;
            remaining_reg <= remaining_next;
            expired_reg   <= (cmd == tmb_pkg::CMD_TICK) ? expired_next : '0;
            finished_reg  <= finished_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign slot_index   = slot_reg;
    assign remaining    = remaining_reg;
    assign expired_mask = expired_reg;
    assign finished     = finished_reg;

`ifndef SYNTHESIS
    // a free slot never counts
    a_running_used: assert property (@(posedge clk) disable iff (!rst_n)
        (running_vec & ~used_vec) == '0)
        else $error("running slot without used mark");

    // input side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result register free");

    // an expiry is only reported by a successful tick
    a_expire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (expired_mask != '0)) |-> ok)
        else $error("expired mask on a failed result");
`endif

endmodule

`default_nettype wire

[rtl/core/tmb_slot_lane.sv]
`default_nettype none

module tmb_slot_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tmb_pkg::lane_req_t req,
    input  wire logic               sel,
    input  wire logic               grant,
    output tmb_pkg::lane_stat_t     stat
);

    logic [tmb_pkg::COUNT_W-1:0] count_reg;
    logic [tmb_pkg::COUNT_W-1:0] count_next;
    logic                        running_reg;
    logic                        running_next;
    logic                        used_reg;
    logic                        used_next;
    logic                        autofree_reg;
    logic                        autofree_next;
    logic [tmb_pkg::COUNT_W-1:0] count_dec;
    logic                        count_zero;
    logic                        expire;

    assign count_dec  = count_reg - tmb_pkg::COUNT_W'(1);
    assign count_zero = (count_reg == '0);

    // a running slot hits zero on this tick
    assign expire = req.fire && (req.cmd == tmb_pkg::CMD_TICK) && running_reg
                    && (count_dec == '0);

    // next slot state for the current request
    always_comb
    begin
        count_next    = count_reg;
        running_next  = running_reg;
        used_next     = used_reg;
        autofree_next = autofree_reg;
        if (req.fire)
        begin
            case (req.cmd)
                tmb_pkg::CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        count_next = count_dec;
                        if (expire)
                        begin
                            running_next = 1'b0;
                            if (autofree_reg)
                            begin
                                used_next     = 1'b0;
                                autofree_next = 1'b0;
                            end
                        end
                    end
                end
                tmb_pkg::CMD_ALLOCATE:
                begin
                    if (grant)
                    begin
                        count_next    = req.time_value;
                        running_next  = 1'b1;
                        used_next     = 1'b1;
                        autofree_next = req.auto_delete;
                    end
                end
                tmb_pkg::CMD_RESTART:
                begin
                    if (sel && count_zero)
                    begin
                        count_next   = req.time_value;
                        running_next = 1'b1;
                        used_next    = 1'b1;
                    end
                end
                tmb_pkg::CMD_PAUSE_RESUME:
                begin
                    if (sel && !count_zero)
                    begin
                        running_next = req.resume;
                    end
                end
                tmb_pkg::CMD_SET_TIME:
                begin
                    if (sel && !count_zero)
                    begin
                        count_next = req.time_value;
                    end
                end
                tmb_pkg::CMD_DELETE:
                begin
                    if (sel && used_reg)
                    begin
                        count_next    = '0;
                        running_next  = 1'b0;
                        used_next     = 1'b0;
                        autofree_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // slot state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            running_reg  <= 1'b0;
            used_reg     <= 1'b0;
            autofree_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            running_reg  <= running_next;
            used_reg     <= used_next;
            autofree_reg <= autofree_next;
        end
    end

    assign stat.count   = count_reg;
    assign stat.running = running_reg;
    assign stat.used    = used_reg;
    assign stat.expire  = expire;

endmodule

`default_nettype wire

[rtl/core/tmb_alloc.sv]
`default_nettype none

module tmb_alloc #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic [TIMER_SLOTS-1:0]    used,
    output logic                           found,
    output logic [TIMER_SLOTS-1:0]         grant,
    output logic [tmb_pkg::INDEX_W-1:0]    slot
);

    // lowest free slot wins
    always_comb
    begin
        found = 1'b0;
        grant = '0;
        slot  = '0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            if (!used[i] && !found)
            begin
                found    = 1'b1;
                grant[i] = 1'b1;
                slot     = tmb_pkg::INDEX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[bench/timer_bank_response_check.sv]
`timescale 1ns / 100ps

module timer_bank_response_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [2:0]                    command,
    input  wire logic [tmb_pkg::INDEX_W-1:0]   timer_index,
    input  wire logic [tmb_pkg::COUNT_W-1:0]   time_value,
    input  wire logic                          auto_delete,
    input  wire logic                          resume,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          ok,
    input  wire logic [tmb_pkg::INDEX_W-1:0]   slot_index,
    input  wire logic [tmb_pkg::COUNT_W-1:0]   remaining,
    input  wire logic [tmb_pkg::MASK_W-1:0]    expired_mask,
    input  wire logic                          finished,
    output int                                 mismatches,
    output int                                 outstanding
);

    import tmb_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] slot_index;
        logic [COUNT_W-1:0] remaining;
        logic [MASK_W-1:0]  expired_mask;
        logic               finished;
    } timer_response_t;

    // mirrored slot state
    logic [COUNT_W-1:0] slot_count [SLOTS];
    logic [SLOTS-1:0]   running_marks;
    logic [SLOTS-1:0]   used_marks;
    logic [SLOTS-1:0]   autofree_marks;

    timer_response_t    awaited_responses [$];
    timer_response_t    oldest;

    function automatic void free_slot(input int i);
        slot_count[i]     = '0;
        running_marks[i]  = 1'b0;
        used_marks[i]     = 1'b0;
        autofree_marks[i] = 1'b0;
    endfunction

    // apply one request to the mirrored bank and return its response
    function automatic timer_response_t apply_timer_command(
        input logic [2:0]         cmd_bits,
        input logic [INDEX_W-1:0] idx,
        input logic [COUNT_W-1:0] tval,
        input logic               autod,
        input logic               run
    );
        timer_response_t rsp;
        logic            found;
        rsp            = '0;
        rsp.slot_index = idx;
        found          = 1'b0;
        case (cmd_bits)
            CMD_TICK:
            begin
                rsp.ok = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (running_marks[i])
                    begin
                        slot_count[i] = slot_count[i] - 1'b1;
                        if (slot_count[i] == '0)
                        begin
                            running_marks[i]    = 1'b0;
                            rsp.expired_mask[i] = 1'b1;
                            if (autofree_marks[i])
                                free_slot(i);
                        end
                    end
                end
            end
            CMD_ALLOCATE:
            begin
                // lowest free slot wins
                rsp.slot_index = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && !used_marks[i])
                    begin
                        found             = 1'b1;
                        slot_count[i]     = tval;
                        running_marks[i]  = 1'b1;
                        used_marks[i]     = 1'b1;
                        autofree_marks[i] = autod;
                        rsp.slot_index    = INDEX_W'(i);
                        rsp.ok            = 1'b1;
                    end
                end
            end
            CMD_RESTART:
            begin
                if (slot_count[idx] == '0)
                begin
                    slot_count[idx]    = tval;
                    running_marks[idx] = 1'b1;
                    used_marks[idx]    = 1'b1;
                    rsp.ok             = 1'b1;
                end
            end
            CMD_PAUSE_RESUME:
            begin
                if (slot_count[idx] != '0)
                begin
                    running_marks[idx] = run;
                    rsp.ok             = 1'b1;
                end
            end
            CMD_SET_TIME:
            begin
                if (slot_count[idx] != '0)
                begin
                    slot_count[idx] = tval;
                    rsp.ok          = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (used_marks[idx])
                begin
                    free_slot(int'(idx));
                    rsp.ok = 1'b1;
                end
            end
            CMD_QUERY:
            begin
                if (used_marks[idx])
                begin
                    rsp.ok        = 1'b1;
                    rsp.remaining = slot_count[idx];
                    rsp.finished  = (slot_count[idx] == '0);
                end
            end
            default:
            begin
                // undefined code: nothing changes
            end
        endcase
        return rsp;
    endfunction

    task automatic compare_field(
        input string       field_name,
        input logic [15:0] want,
        input logic [15:0] got
    );
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
            mismatches++;
        end
    endtask

    // responses checked against the oldest request, new requests predicted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_count[i] = '0;
            running_marks  = '0;
            used_marks     = '0;
            autofree_marks = '0;
            awaited_responses.delete();
            mismatches     = 0;
            outstanding   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_responses.size() == 0)
                begin
                    $display("%0t: response with no request outstanding, slot_index %0h",
                             $time, slot_index);
                    mismatches++;
                end
                else
                begin
                    oldest = awaited_responses.pop_front();
                    compare_field("ok", 16'(oldest.ok), 16'(ok));
                    compare_field("slot_index", 16'(oldest.slot_index), 16'(slot_index));
                    compare_field("remaining", oldest.remaining, remaining);
                    compare_field("expired_mask", oldest.expired_mask, expired_mask);
                    compare_field("finished", 16'(oldest.finished), 16'(finished));
                end
            end
            if (in_valid && !in_stall)
                awaited_responses.push_back(apply_timer_command(command, timer_index,
                                                                time_value, auto_delete,
                                                                resume));
            outstanding <= awaited_responses.size();
        end
    end

endmodule

[bench/multi_slot_timer_bank_test.sv]
`timescale 1ns / 100ps

module multi_slot_timer_bank_test;

    import tmb_pkg::*;

    localparam logic [2:0] CMD_UNDEFINED = 3'd7;

    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_REQUESTS = 1750;
    localparam int CALM_REQUESTS   = 250;
    localparam int HOLD_AT         = 300;
    localparam int DRAIN_AT        = 900;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 400000;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [2:0]          command      = '0;
    logic [INDEX_W-1:0]  timer_index  = '0;
    logic [COUNT_W-1:0]  time_value   = '0;
    logic                auto_delete  = 1'b0;
    logic                resume       = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                ok;
    logic [INDEX_W-1:0]  slot_index;
    logic [COUNT_W-1:0]  remaining;
    logic [MASK_W-1:0]   expired_mask;
    logic                finished;

    int                  mismatches;
    int                  outstanding;
    int                  cycles       = 0;
    int                  hold_asks    = 0;
    logic                calm         = 1'b0;

    multi_slot_timer_bank dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .timer_index  (timer_index),
        .time_value   (time_value),
        .auto_delete  (auto_delete),
        .resume       (resume),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .slot_index   (slot_index),
        .remaining    (remaining),
        .expired_mask (expired_mask),
        .finished     (finished)
    );

    timer_bank_response_check response_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .timer_index  (timer_index),
        .time_value   (time_value),
        .auto_delete  (auto_delete),
        .resume       (resume),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .slot_index   (slot_index),
        .remaining    (remaining),
        .expired_mask (expired_mask),
        .finished     (finished),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL multi_slot_timer_bank");
            $finish;
        end
    end

    // offer one request, wait for acceptance, maybe idle afterwards
    task automatic send_request(
        input logic [2:0]         cmd,
        input logic [INDEX_W-1:0] idx,
        input logic [COUNT_W-1:0] tval,
        input logic               autod,
        input logic               run
    );
        in_valid    <= 1'b1;
        command     <= cmd;
        timer_index <= idx;
        time_value  <= tval;
        auto_delete <= autod;
        resume      <= run;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // weighted command mix, small counts so slots expire often
    task automatic random_request();
        int unsigned        pick;
        logic [2:0]         cmd;
        logic [INDEX_W-1:0] idx;
        logic [COUNT_W-1:0] tval;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            cmd = CMD_TICK;
        else if (pick < 45)
            cmd = CMD_ALLOCATE;
        else if (pick < 55)
            cmd = CMD_RESTART;
        else if (pick < 65)
            cmd = CMD_PAUSE_RESUME;
        else if (pick < 75)
            cmd = CMD_SET_TIME;
        else if (pick < 83)
            cmd = CMD_DELETE;
        else if (pick < 98)
            cmd = CMD_QUERY;
        else
            cmd = CMD_UNDEFINED;
        // low slots are the ones allocate hands out first
        if ($urandom_range(0, 1) == 0)
            idx = INDEX_W'($urandom_range(0, 15));
        else
            idx = INDEX_W'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0, 1:    tval = COUNT_W'($urandom);
            2:       tval = COUNT_W'(16'hFFFF - $urandom_range(0, 2));
            default: tval = COUNT_W'($urandom_range(0, 6));
        endcase
        send_request(cmd, idx, tval, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // result side stalls
    initial
    begin : stall_driver
        int hold_seen;
        hold_seen = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_asks != hold_seen)
            begin
                // long hold so the bank backs up into its input
                hold_seen = hold_asks;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero loaded while running, then wrap on tick
        send_request(CMD_ALLOCATE, 4'd0, 16'h0000, 1'b0, 1'b0);
        send_request(CMD_TICK, 4'hF, 16'hFFFF, 1'b1, 1'b1);
        send_request(CMD_QUERY, 4'd0, 16'h0000, 1'b0, 1'b0);

        // fill the bank, alternating auto-free
        for (int s = 1; s < 16; s++)
            send_request(CMD_ALLOCATE, 4'd0, (s == 1) ? 16'hFFFF : COUNT_W'(s - 1),
                         1'(s % 2), 1'b0);
        // bank full
        send_request(CMD_ALLOCATE, 4'd5, 16'h1234, 1'b1, 1'b0);

        // slot 2 expires and stays, slot 3 expires and is freed
        send_request(CMD_TICK, 4'd0, 16'h0000, 1'b0, 1'b0);
        send_request(CMD_TICK, 4'd0, 16'h0000, 1'b0, 1'b0);
        send_request(CMD_QUERY, 4'd2, 16'h0000, 1'b0, 1'b0);
        send_request(CMD_QUERY, 4'd3, 16'h0000, 1'b0, 1'b0);

        // restart of a finished slot, pause, set to zero, resume refused
        send_request(CMD_RESTART, 4'd2, 16'hFFFF, 1'b0, 1'b0);
        send_request(CMD_PAUSE_RESUME, 4'd2, 16'h0000, 1'b0, 1'b0);
        send_request(CMD_SET_TIME, 4'd2, 16'h0000, 1'b0, 1'b0);
        send_request(CMD_PAUSE_RESUME, 4'd2, 16'h0000, 1'b0, 1'b1);

        // restart of a free slot, delete, undefined code
        send_request(CMD_RESTART, 4'd3, 16'd5, 1'b1, 1'b1);
        send_request(CMD_DELETE, 4'd1, 16'h0000, 1'b0, 1'b0);
        send_request(CMD_DELETE, 4'd1, 16'h0000, 1'b0, 1'b0);
        send_request(CMD_UNDEFINED, 4'hF, 16'hFFFF, 1'b1, 1'b1);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == HOLD_AT)
                hold_asks <= hold_asks + 1;
            if (n == DRAIN_AT)
            begin
                // let every response come back before going on
                in_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            if (n == RANDOM_REQUESTS - CALM_REQUESTS)
                calm <= 1'b1;
            random_request();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("PASS multi_slot_timer_bank");
        else
            $display("FAIL multi_slot_timer_bank");
        $finish;
    end

endmodule

[sim.f]
rtl/core/tmb_pkg.sv
rtl/core/tmb_slot_lane.sv
rtl/core/tmb_alloc.sv
rtl/core/multi_slot_timer_bank.sv
bench/timer_bank_response_check.sv
bench/multi_slot_timer_bank_test.sv
